@@ hdl/rfm_pkg.sv @@
// Shared types, constants and the CRC column function for the reply frame matcher.
`timescale 1ns / 1ps
`default_nettype none
package rfm_pkg;

  localparam int unsigned FRAME_LEN = 6;
  localparam int unsigned CRC_SPAN = 5;
  localparam int unsigned CRC_BITS = CRC_SPAN * 8;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'h00;
  localparam logic [7:0] SCAN_LIMIT_RESET = 8'd32;
  localparam logic [7:0] BYTES_SEEN_MAX = 8'd255;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_FOUND     = 2'd1,
    ST_TIMEOUT   = 2'd2,
    ST_IDLE      = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] payload;
  } result_t;

  // Reflected CRC-8 of a message of CRC_SPAN bytes in which only bit k is set,
  // starting from the given initial value. Only evaluated at elaboration; a
  // value of k at or beyond CRC_BITS gives the contribution of the initial value.
  function automatic logic [7:0] crc_column(input int unsigned k, input logic [7:0] init);
    logic [7:0] crc;
    logic       fb;
    logic       v;
    crc = init;
    for (int unsigned i = 0; i < CRC_BITS; i++) begin
      v = (i == k);
      fb = crc[0] ^ v;
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

@@ hdl/rfm_if.sv @@
// Word channel interfaces for the input, result and configuration ports.
`timescale 1ns / 1ps
`default_nettype none
interface rfm_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] expected_id;
  logic [7:0] rx_byte;
  modport source (output valid, output restart, output expected_id, output rx_byte,
                  input ready);
  modport sink (input valid, input restart, input expected_id, input rx_byte,
                output ready);
endinterface

interface rfm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] payload;
  modport source (output valid, output status, output payload, input ready);
  modport sink (input valid, input status, input payload, output ready);
endinterface

interface rfm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/rfm_crc8.sv @@
// Reflected CRC-8 of five bytes as a single XOR network.
`timescale 1ns / 1ps
`default_nettype none
module rfm_crc8 (
  input  wire logic [rfm_pkg::CRC_BITS-1:0] data,
  output logic [7:0]                        crc
);

  localparam logic [7:0] CRC_BASE = rfm_pkg::crc_column(rfm_pkg::CRC_BITS, rfm_pkg::CRC_INIT);

  logic [7:0] term [rfm_pkg::CRC_BITS];

  for (genvar k = 0; k < rfm_pkg::CRC_BITS; k++) begin : g_col
    localparam logic [7:0] COL = rfm_pkg::crc_column(k, 8'h00);
    assign term[k] = data[k] ? COL : 8'h00;
  end

  always_comb begin
    crc = CRC_BASE;
    for (int unsigned k = 0; k < rfm_pkg::CRC_BITS; k++) begin
      crc = crc ^ term[k];
    end
  end

endmodule
`default_nettype wire

@@ hdl/rfm_search.sv @@
// Search state: byte window, target id, byte count and the match decision.
`timescale 1ns / 1ps
`default_nettype none
module rfm_search (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       restart,
  input  wire logic [7:0] expected_id,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] scan_limit,
  output rfm_pkg::result_t result
);

  logic [7:0] window_r [rfm_pkg::FRAME_LEN];
  logic [7:0] window_nxt [rfm_pkg::FRAME_LEN];
  logic [7:0] target_id_r, target_id_nxt;
  logic [7:0] bytes_seen_r, bytes_seen_nxt;
  logic       finished_r, finished_nxt;
  logic [rfm_pkg::CRC_BITS-1:0] crc_data;
  logic [7:0] crc;
  logic       match;

  // After the shift, bytes one to five of the current window become the first
  // five of the new one, so the check runs on the stored bytes directly.
  always_comb begin
    for (int unsigned i = 0; i < rfm_pkg::CRC_SPAN; i++) begin
      crc_data[i*8 +: 8] = window_r[i+1];
    end
  end

  rfm_crc8 u_crc (
    .data (crc_data),
    .crc  (crc)
  );

  always_comb begin
    for (int unsigned i = 0; i < rfm_pkg::FRAME_LEN - 1; i++) begin
      window_nxt[i] = window_r[i+1];
    end
    window_nxt[rfm_pkg::FRAME_LEN-1] = rx_byte;
    bytes_seen_nxt = (bytes_seen_r == rfm_pkg::BYTES_SEEN_MAX) ? bytes_seen_r
                                                              : bytes_seen_r + 8'd1;
    target_id_nxt = target_id_r;
    finished_nxt = finished_r;
    match = (bytes_seen_nxt >= 8'(rfm_pkg::FRAME_LEN)) && (window_r[1] == target_id_r)
            && (rx_byte == crc);
    result.status = rfm_pkg::ST_SEARCHING;
    result.payload = 32'd0;

    if (restart) begin
      for (int unsigned i = 0; i < rfm_pkg::FRAME_LEN; i++) begin
        window_nxt[i] = 8'h00;
      end
      bytes_seen_nxt = 8'd0;
      target_id_nxt = expected_id;
      finished_nxt = 1'b0;
    end else if (finished_r) begin
      for (int unsigned i = 0; i < rfm_pkg::FRAME_LEN; i++) begin
        window_nxt[i] = window_r[i];
      end
      bytes_seen_nxt = bytes_seen_r;
      result.status = rfm_pkg::ST_IDLE;
    end else if (match) begin
      result.status = rfm_pkg::ST_FOUND;
      result.payload = {window_r[5], window_r[4], window_r[3], window_r[2]};
      finished_nxt = 1'b1;
    end else if (bytes_seen_nxt >= scan_limit) begin
      result.status = rfm_pkg::ST_TIMEOUT;
      finished_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < rfm_pkg::FRAME_LEN; i++) begin
        window_r[i] <= 8'h00;
      end
      target_id_r <= 8'h00;
      bytes_seen_r <= 8'd0;
      finished_r <= 1'b1;
    end else if (accept) begin
      window_r <= window_nxt;
      target_id_r <= target_id_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/response_frame_matcher_crc8_core.sv @@
// Top level of the reply frame matcher with CRC-8 check.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted input word gives exactly one result word in the next cycle.
// A word is taken in every cycle in which the output register is empty or
// is being emptied, so the block sustains one word per clock; the only limit
// is the single output register and the readiness of its consumer. The window
// shift and the CRC check of the five stored bytes are evaluated in the same
// cycle as the incoming byte. The scan limit register is written through the
// configuration channel, which is always ready.
module response_frame_matcher_crc8_core (
  input wire logic   clk,
  input wire logic   rst_n,
  rfm_in_if.sink     in_ch,
  rfm_out_if.source  out_ch,
  rfm_cfg_if.sink    cfg_ch
);

  logic              out_valid_r, out_valid_nxt;
  rfm_pkg::result_t  out_word_r;
  rfm_pkg::result_t  result;
  logic [7:0]        scan_limit_r;
  logic              accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  rfm_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .restart     (in_ch.restart),
    .expected_id (in_ch.expected_id),
    .rx_byte     (in_ch.rx_byte),
    .scan_limit  (scan_limit_r),
    .result      (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      scan_limit_r <= rfm_pkg::SCAN_LIMIT_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        scan_limit_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_word_r.status;
  assign out_ch.payload = out_word_r.payload;

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the reply frame matcher with CRC-8 check.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    logic       restart;
    logic [7:0] id;
    logic [7:0] data;
  } rx_word_t;

  logic clk;
  logic rst_n;

  rfm_in_if  in_ch ();
  rfm_out_if out_ch ();
  rfm_cfg_if cfg_ch ();

  response_frame_matcher_crc8_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rx_word_t          rx_words[$];
  rfm_pkg::result_t  predicted_results[$];
  int                mismatches = 0;
  int                quiet_cycles = 0;
  bit                gaps_on = 1'b1;

  logic [7:0] win_bytes[rfm_pkg::FRAME_LEN];
  logic [7:0] target_id;
  logic [7:0] bytes_seen;
  logic       search_done;
  logic [7:0] limit_model;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] crc8_reflected(input logic [39:0] msg);
    logic [7:0] crc;
    logic       fb;
    crc = rfm_pkg::CRC_INIT;
    for (int i = 0; i < 40; i++) begin
      fb = crc[0] ^ msg[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ rfm_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic rfm_pkg::result_t match_byte(input logic rs, input logic [7:0] id,
                                                  input logic [7:0] b);
    rfm_pkg::result_t r;
    logic [7:0]       crc;
    r.status = rfm_pkg::ST_SEARCHING;
    r.payload = '0;
    if (rs) begin
      target_id = id;
      for (int i = 0; i < rfm_pkg::FRAME_LEN; i++) win_bytes[i] = 8'h00;
      bytes_seen = 8'd0;
      search_done = 1'b0;
    end else if (search_done) begin
      r.status = rfm_pkg::ST_IDLE;
    end else begin
      for (int i = 0; i < rfm_pkg::FRAME_LEN - 1; i++) win_bytes[i] = win_bytes[i + 1];
      win_bytes[rfm_pkg::FRAME_LEN - 1] = b;
      if (bytes_seen != 8'd255) begin
        bytes_seen = bytes_seen + 8'd1;
      end
      crc = crc8_reflected({win_bytes[4], win_bytes[3], win_bytes[2], win_bytes[1],
                            win_bytes[0]});
      if (bytes_seen >= rfm_pkg::FRAME_LEN && win_bytes[0] == target_id
          && win_bytes[rfm_pkg::FRAME_LEN - 1] == crc) begin
        r.status = rfm_pkg::ST_FOUND;
        r.payload = {win_bytes[4], win_bytes[3], win_bytes[2], win_bytes[1]};
        search_done = 1'b1;
      end else if (bytes_seen >= limit_model) begin
        r.status = rfm_pkg::ST_TIMEOUT;
        search_done = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : driver
    rx_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(match_byte(in_ch.restart, in_ch.expected_id,
                                               in_ch.rx_byte));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_words.size() > 0 && !(gaps_on && $urandom_range(99) < 10)) begin
          w = rx_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.restart <= w.restart;
          in_ch.expected_id <= w.id;
          in_ch.rx_byte <= w.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    rfm_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result word with none predicted: status %0d, payload %h",
                 out_ch.status, out_ch.payload);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.payload !== want.payload) begin
            $error("payload: expected %h, actual %h", want.payload, out_ch.payload);
            mismatches++;
          end
        end
      end
      out_ch.ready <= !(gaps_on && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push(input logic rs, input logic [7:0] id, input logic [7:0] b);
    rx_word_t w;
    w.restart = rs;
    w.id = id;
    w.data = b;
    rx_words.push_back(w);
  endtask

  task automatic push_frame(input logic [7:0] id, input logic [31:0] pl, input int flip);
    logic [47:0] frame;
    frame[39:0] = {pl, id};
    frame[47:40] = crc8_reflected(frame[39:0]);
    if (flip >= 0) begin
      frame[flip] = ~frame[flip];
    end
    for (int i = 0; i < rfm_pkg::FRAME_LEN; i++) push(1'b0, 8'h00, frame[8*i +: 8]);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (rx_words.size() != 0 || in_ch.valid || predicted_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_scan_limit(input logic [7:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    limit_model = v;
    @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    int         cnt;
    int         noise;
    logic [7:0] id;
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(9))
        0: begin
          push(1'b0, 8'($urandom), 8'($urandom));
          cnt++;
        end
        1: begin
          push(1'b1, 8'($urandom), 8'($urandom));
          repeat ($urandom_range(0, 8)) push(1'b0, 8'($urandom), 8'($urandom));
          cnt += 5;
        end
        default: begin
          id = 8'($urandom);
          push(1'b1, id, 8'($urandom));
          noise = ($urandom_range(3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
          for (int i = 0; i < noise; i++) begin
            push(1'b0, 8'($urandom), ($urandom_range(3) == 0) ? id : 8'($urandom));
          end
          push_frame(id, $urandom, ($urandom_range(4) == 0) ? $urandom_range(0, 47) : -1);
          repeat ($urandom_range(0, 2)) push(1'b0, 8'($urandom), 8'($urandom));
          cnt += noise + 8;
        end
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    in_ch.expected_id = 8'h00;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 8'h00;
    for (int i = 0; i < rfm_pkg::FRAME_LEN; i++) win_bytes[i] = 8'h00;
    target_id = 8'h00;
    bytes_seen = 8'd0;
    search_done = 1'b1;
    limit_model = rfm_pkg::SCAN_LIMIT_RESET;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push(1'b0, 8'hFF, 8'hFF);
    push(1'b1, 8'h00, 8'hFF);
    repeat (6) push(1'b0, 8'h00, 8'h00);
    push(1'b0, 8'hFF, 8'h00);
    push(1'b1, 8'hFF, 8'h00);
    push_frame(8'hFF, 32'hFFFF_FFFF, -1);
    push(1'b1, 8'h5A, 8'h00);
    push(1'b0, 8'h00, 8'h5A);
    push(1'b0, 8'hFF, 8'h3C);
    push(1'b1, 8'hA5, 8'hC3);
    push_frame(8'hA5, 32'h8000_0001, -1);
    drain();

    set_scan_limit(8'd6);
    push(1'b1, 8'h3C, 8'h00);
    push_frame(8'h3C, $urandom, -1);
    random_phase(35);
    drain();

    set_scan_limit(8'd0);
    random_phase(15);
    drain();

    set_scan_limit(8'd1);
    random_phase(15);
    drain();

    set_scan_limit(8'd5);
    random_phase(25);
    drain();

    set_scan_limit(8'd255);
    gaps_on = 1'b0;
    push(1'b1, 8'h81, 8'h00);
    repeat (257) push(1'b0, 8'h00, 8'h7E);
    random_phase(35);
    drain();
    gaps_on = 1'b1;

    set_scan_limit(8'($urandom_range(6, 255)));
    random_phase(35);
    drain();

    set_scan_limit(rfm_pkg::SCAN_LIMIT_RESET);
    random_phase(40);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rfm_pkg.sv
hdl/rfm_if.sv
hdl/rfm_crc8.sv
hdl/rfm_search.sv
hdl/response_frame_matcher_crc8_core.sv
bench/tb.sv
